### rtl/cre_pkg.sv
`timescale 1ns / 1ps
package cre_pkg;
   localparam int RULE_COUNT = 16;
   localparam int IDX_W = $clog2(RULE_COUNT);
   localparam logic [6:0] MAX_COIL = 7'd100;

   typedef enum logic [2:0] {
      CMD_TICK = 3'd0, CMD_ADD = 3'd1, CMD_RELEASE = 3'd2,
      CMD_CLEAR = 3'd3, CMD_CLEAR_ALL = 3'd4, CMD_STOP_ALL = 3'd5,
      CMD_RSV6 = 3'd6, CMD_RSV7 = 3'd7
   } cmd_type;

   localparam logic [2:0] T_EMPTY = 3'd0;
   localparam logic [2:0] T_PULSE = 3'd1;
   localparam logic [2:0] T_ENABLE = 3'd2;
   localparam logic [2:0] T_HIT = 3'd3;
   localparam logic [2:0] T_HIT_REL = 3'd4;
   localparam logic [2:0] T_HIT_EN_REL = 3'd5;
   localparam logic [2:0] T_HIT_EN_REL_DIS = 3'd6;

   localparam logic [3:0] S_DISABLED = 4'd0;
   localparam logic [3:0] S_ENABLED = 4'd1;
   localparam logic [3:0] S_ACTIVATED = 4'd2;
   localparam logic [3:0] S_WAIT_REL = 4'd3;
   localparam logic [3:0] S_START_DUR = 4'd4;
   localparam logic [3:0] S_WAIT_DUR = 4'd5;
   localparam logic [3:0] S_RELEASE = 4'd6;
   localparam logic [3:0] S_WAIT_FINAL = 4'd7;
   localparam logic [3:0] S_CLEAR = 4'd8;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NO_SWITCH = 3'd1;
   localparam logic [2:0] ST_BAD_COIL = 3'd2;
   localparam logic [2:0] ST_SW_REQUIRED = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   typedef struct packed {
      logic [2:0]  rtype;
      logic [5:0]  sw;
      logic [6:0]  coil;
      logic [3:0]  st;
      logic [15:0] timeout;
      logic [15:0] duration;
   } rule_type;

   typedef enum logic [1:0] {
      FSM_IDLE, FSM_SCAN, FSM_STATUS
   } fsm_type;

   typedef struct packed {
      logic       wr;
      logic [6:0] coil;
      logic       level;
   } emit_type;
endpackage

### rtl/cre_step.sv
`timescale 1ns / 1ps
module cre_step (
   input  cre_pkg::rule_type r_in,
   input  cre_pkg::cmd_type  cmd,
   input  logic [2:0]        rule_type_in,
   input  logic [5:0]        sw_in,
   input  logic [6:0]        coil_in,
   input  logic [15:0]       duration_in,
   input  logic [15:0]       now,
   input  logic [63:0]       active,
   input  logic              found,
   output cre_pkg::rule_type r_out,
   output logic              hit,
   output cre_pkg::emit_type emit
);
   logic on;
   always_comb begin
      r_out = r_in;
      hit = 1'b0;
      emit = '0;
      on = (r_in.sw != 6'd0) && active[r_in.sw];
      case (cmd)
         cre_pkg::CMD_TICK: begin
            if (r_in.rtype != cre_pkg::T_EMPTY) begin
               case (r_in.st)
                  cre_pkg::S_ENABLED: begin
                     if (r_in.sw == 6'd0 || on) begin
                        emit = '{wr: 1'b1, coil: r_in.coil, level: 1'b1};
                        r_out.st = cre_pkg::S_ACTIVATED;
                     end
                  end
                  cre_pkg::S_ACTIVATED: begin
                     if (r_in.rtype == cre_pkg::T_HIT || r_in.rtype == cre_pkg::T_PULSE)
                        r_out.st = cre_pkg::S_START_DUR;
                     else if (r_in.rtype inside {cre_pkg::T_HIT_EN_REL,
                              cre_pkg::T_HIT_EN_REL_DIS, cre_pkg::T_HIT_REL})
                        r_out.st = cre_pkg::S_WAIT_REL;
                     else if (r_in.rtype != cre_pkg::T_ENABLE)
                        r_out.st = cre_pkg::S_RELEASE;
                  end
                  cre_pkg::S_WAIT_REL: begin
                     if (!on) r_out.st = cre_pkg::S_RELEASE;
                  end
                  cre_pkg::S_START_DUR: begin
                     r_out.timeout = now + r_in.duration;
                     r_out.st = cre_pkg::S_WAIT_DUR;
                  end
                  cre_pkg::S_WAIT_DUR: begin
                     if (now > r_in.timeout)
                        r_out.st = (r_in.rtype == cre_pkg::T_PULSE) ?
                                   cre_pkg::S_CLEAR : cre_pkg::S_RELEASE;
                  end
                  cre_pkg::S_RELEASE: begin
                     emit = '{wr: 1'b1, coil: r_in.coil, level: 1'b0};
                     r_out.st = cre_pkg::S_WAIT_FINAL;
                     r_out.timeout = 16'd0;
                  end
                  cre_pkg::S_WAIT_FINAL: begin
                     if (!on)
                        r_out.st = (r_in.rtype == cre_pkg::T_ENABLE) ?
                                   cre_pkg::S_CLEAR : cre_pkg::S_ENABLED;
                  end
                  cre_pkg::S_CLEAR: begin
                     emit = '{wr: 1'b1, coil: r_in.coil, level: 1'b0};
                     r_out.rtype = cre_pkg::T_EMPTY;
                     r_out.st = cre_pkg::S_DISABLED;
                  end
                  default: ;
               endcase
            end
         end
         cre_pkg::CMD_ADD: begin
            if (!found && (r_in.rtype == cre_pkg::T_EMPTY ||
                (r_in.coil == coil_in && r_in.sw == sw_in))) begin
               hit = 1'b1;
               r_out = '{rtype: rule_type_in, sw: sw_in, coil: coil_in,
                         st: cre_pkg::S_ENABLED, timeout: 16'd0, duration: duration_in};
               emit = '{wr: 1'b1, coil: coil_in, level: 1'b0};
            end
         end
         cre_pkg::CMD_RELEASE: begin
            if (!found && r_in.rtype == cre_pkg::T_ENABLE && r_in.coil == coil_in) begin
               hit = 1'b1;
               r_out.st = cre_pkg::S_RELEASE;
            end
         end
         cre_pkg::CMD_CLEAR: begin
            if (!found && r_in.sw == sw_in && r_in.coil == coil_in) begin
               hit = 1'b1;
               r_out.st = cre_pkg::S_CLEAR;
            end
         end
         cre_pkg::CMD_CLEAR_ALL: r_out.st = cre_pkg::S_CLEAR;
         cre_pkg::CMD_STOP_ALL: begin
            if (r_in.rtype != cre_pkg::T_EMPTY && r_in.st != cre_pkg::S_DISABLED)
               r_out.st = cre_pkg::S_RELEASE;
         end
         default: ;
      endcase
   end
endmodule

### rtl/coil_rule_engine_core.sv
`timescale 1ns / 1ps
// channel   | ports                          | handshake
// request   | req_* fields                   | start & !busy
// result    | rsp_* fields                   | rsp_valid, one cycle, no stall
// config    | psel penable pwrite paddr ...  | APB, pready always high
// A scan command walks all RULE_COUNT slots, one per cycle through one step unit,
// then emits status. Add with a failed check skips the scan, as do the reserved
// commands. Coil writes come out during the walk.
// Reset clears every rule valid bit and switch_present; busy holds while working.
module coil_rule_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [2:0]  req_rule_type,
   input  logic [5:0]  req_enable_switch,
   input  logic [6:0]  req_coil,
   input  logic [15:0] req_duration,
   input  logic [15:0] req_now,
   input  logic [63:0] req_switch_active,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_coil_number,
   output logic        rsp_level,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   localparam int IW = cre_pkg::IDX_W;
   cre_pkg::fsm_type fsm_ff, fsm_in;
   cre_pkg::rule_type table_ff [cre_pkg::RULE_COUNT];
   logic [cre_pkg::RULE_COUNT-1:0] valid_ff;
   logic [63:0] present_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [2:0] status_ff, status_in;
   cre_pkg::cmd_type cmd_ff;
   logic [2:0] typ_ff;
   logic [5:0] sw_ff;
   logic [6:0] coil_ff;
   logic [15:0] dur_ff, now_ff;
   logic [63:0] act_ff;
   cre_pkg::rule_type cur_ff, nxt;
   logic hit, wr;
   cre_pkg::emit_type emit;
   logic [2:0] chk;

   assign pready = 1'b1;
   assign prdata = present_ff;
   assign busy = (fsm_ff != cre_pkg::FSM_IDLE);

   cre_step u_step (
      .r_in(cur_ff), .cmd(cmd_ff), .rule_type_in(typ_ff), .sw_in(sw_ff),
      .coil_in(coil_ff), .duration_in(dur_ff), .now(now_ff), .active(act_ff),
      .found(found_ff), .r_out(nxt), .hit(hit), .emit(emit)
   );

   always_comb begin
      chk = cre_pkg::ST_OK;
      if (req_enable_switch != 6'd0 && !present_ff[req_enable_switch])
         chk = cre_pkg::ST_NO_SWITCH;
      else if (req_coil == 7'd0 || req_coil > cre_pkg::MAX_COIL)
         chk = cre_pkg::ST_BAD_COIL;
      else if (req_enable_switch == 6'd0 && req_rule_type >= cre_pkg::T_HIT &&
               req_rule_type <= cre_pkg::T_HIT_EN_REL_DIS)
         chk = cre_pkg::ST_SW_REQUIRED;
   end

   always_comb begin
      fsm_in = fsm_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      status_in = status_ff;
      wr = 1'b0;
      rsp_valid = 1'b0;
      rsp_kind = 1'b0;
      rsp_status = 3'd0;
      rsp_coil_number = 7'd0;
      rsp_level = 1'b0;
      rsp_last = 1'b0;
      case (fsm_ff)
         cre_pkg::FSM_IDLE: begin
            if (start) begin
               idx_in = '0;
               found_in = 1'b0;
               status_in = cre_pkg::ST_OK;
               if (req_command == cre_pkg::CMD_ADD && chk != cre_pkg::ST_OK) begin
                  status_in = chk;
                  fsm_in = cre_pkg::FSM_STATUS;
               end else if (req_command == cre_pkg::CMD_RSV6 ||
                            req_command == cre_pkg::CMD_RSV7)
                  fsm_in = cre_pkg::FSM_STATUS;
               else
                  fsm_in = cre_pkg::FSM_SCAN;
            end
         end
         cre_pkg::FSM_SCAN: begin
            wr = 1'b1;
            if (hit) found_in = 1'b1;
            rsp_valid = emit.wr;
            rsp_kind = emit.wr;
            rsp_coil_number = emit.coil;
            rsp_level = emit.level;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IW'(cre_pkg::RULE_COUNT - 1)) begin
               fsm_in = cre_pkg::FSM_STATUS;
               if (cmd_ff == cre_pkg::CMD_ADD && !(found_ff || hit))
                  status_in = cre_pkg::ST_TABLE_FULL;
               if (cmd_ff == cre_pkg::CMD_RELEASE && !(found_ff || hit))
                  status_in = cre_pkg::ST_NOT_FOUND;
            end
         end
         cre_pkg::FSM_STATUS: begin
            rsp_valid = 1'b1;
            rsp_status = status_ff;
            rsp_last = 1'b1;
            fsm_in = cre_pkg::FSM_IDLE;
         end
         default: fsm_in = cre_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= cre_pkg::FSM_IDLE;
         valid_ff <= '0;
         present_ff <= '0;
         idx_ff <= '0;
         found_ff <= 1'b0;
         status_ff <= 3'd0;
      end else begin
         fsm_ff <= fsm_in;
         idx_ff <= idx_in;
         found_ff <= found_in;
         status_ff <= status_in;
         if (psel && penable && pwrite && !paddr) present_ff <= pwdata;
         if (wr) valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) table_ff[idx_ff] <= nxt;
      cur_ff <= valid_ff[idx_in] ? table_ff[idx_in] : '0;
      if (fsm_ff == cre_pkg::FSM_IDLE && start) begin
         cmd_ff <= cre_pkg::cmd_type'(req_command);
         typ_ff <= req_rule_type;
         sw_ff <= req_enable_switch;
         coil_ff <= req_coil;
         dur_ff <= req_duration;
         now_ff <= req_now;
         act_ff <= req_switch_active & present_ff;
      end
   end

`ifndef SYNTHESIS
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !busy) else $error("status not final");
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid && !rsp_kind) else $error("bad status item");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
`endif
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   typedef struct {
      logic       kind;
      logic [2:0] status;
      logic [6:0] coil_number;
      logic       level;
      logic       last;
   } coil_result_type;

   class scoreboard_type;
      cre_pkg::rule_type rules[cre_pkg::RULE_COUNT];
      logic [63:0]       present;
      coil_result_type   pending[$];
      int                errors;

      function void clear_table();
         foreach (rules[i]) rules[i] = '0;
         present = '0;
         pending.delete();
         errors = 0;
      endfunction

      function void push_write(logic [6:0] c, logic lvl);
         coil_result_type r;
         r.kind = 1'b1;
         r.status = cre_pkg::ST_OK;
         r.coil_number = c;
         r.level = lvl;
         r.last = 1'b0;
         pending.push_back(r);
      endfunction

      function void push_status(logic [2:0] s);
         coil_result_type r;
         r.kind = 1'b0;
         r.status = s;
         r.coil_number = '0;
         r.level = 1'b0;
         r.last = 1'b1;
         pending.push_back(r);
      endfunction

      function void step_rule(int i, logic [15:0] now, logic [63:0] act);
         logic on;
         on = 1'b0;
         if (rules[i].st == cre_pkg::S_DISABLED) return;
         if (rules[i].sw != 0) on = act[rules[i].sw];
         case (rules[i].st)
            cre_pkg::S_ENABLED: begin
               if (rules[i].sw == 0 || on) begin
                  push_write(rules[i].coil, 1'b1);
                  rules[i].st = cre_pkg::S_ACTIVATED;
               end
            end
            cre_pkg::S_ACTIVATED: begin
               if (rules[i].rtype == cre_pkg::T_HIT || rules[i].rtype == cre_pkg::T_PULSE)
                  rules[i].st = cre_pkg::S_START_DUR;
               else if (rules[i].rtype == cre_pkg::T_HIT_EN_REL
                        || rules[i].rtype == cre_pkg::T_HIT_EN_REL_DIS
                        || rules[i].rtype == cre_pkg::T_HIT_REL)
                  rules[i].st = cre_pkg::S_WAIT_REL;
               else if (rules[i].rtype != cre_pkg::T_ENABLE)
                  rules[i].st = cre_pkg::S_RELEASE;
            end
            cre_pkg::S_WAIT_REL:
               if (rules[i].sw == 0 || !on) rules[i].st = cre_pkg::S_RELEASE;
            cre_pkg::S_START_DUR: begin
               rules[i].timeout = now + rules[i].duration;
               rules[i].st = cre_pkg::S_WAIT_DUR;
            end
            cre_pkg::S_WAIT_DUR: begin
               if (now > rules[i].timeout)
                  rules[i].st = (rules[i].rtype == cre_pkg::T_PULSE) ?
                                cre_pkg::S_CLEAR : cre_pkg::S_RELEASE;
            end
            cre_pkg::S_RELEASE: begin
               push_write(rules[i].coil, 1'b0);
               rules[i].st = cre_pkg::S_WAIT_FINAL;
               rules[i].timeout = '0;
            end
            cre_pkg::S_WAIT_FINAL: begin
               if (rules[i].sw == 0 || !on)
                  rules[i].st = (rules[i].rtype == cre_pkg::T_ENABLE) ?
                                cre_pkg::S_CLEAR : cre_pkg::S_ENABLED;
            end
            cre_pkg::S_CLEAR: begin
               push_write(rules[i].coil, 1'b0);
               rules[i].rtype = cre_pkg::T_EMPTY;
               rules[i].st = cre_pkg::S_DISABLED;
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic [2:0] cmd, logic [2:0] typ, logic [5:0] sw,
                                 logic [6:0] c, logic [15:0] dur, logic [15:0] now,
                                 logic [63:0] act_in);
         logic [63:0] act;
         logic        done;
         act = act_in & present;
         done = 1'b0;
         case (cmd)
            cre_pkg::CMD_TICK: begin
               for (int i = 0; i < cre_pkg::RULE_COUNT; i++)
                  if (rules[i].rtype != cre_pkg::T_EMPTY) step_rule(i, now, act);
               push_status(cre_pkg::ST_OK);
            end
            cre_pkg::CMD_ADD: begin
               if (sw != 0 && !present[sw]) push_status(cre_pkg::ST_NO_SWITCH);
               else if (c == 0 || c > cre_pkg::MAX_COIL) push_status(cre_pkg::ST_BAD_COIL);
               else if (sw == 0 && typ >= cre_pkg::T_HIT && typ <= cre_pkg::T_HIT_EN_REL_DIS)
                  push_status(cre_pkg::ST_SW_REQUIRED);
               else begin
                  for (int i = 0; i < cre_pkg::RULE_COUNT && !done; i++)
                     if (rules[i].rtype == cre_pkg::T_EMPTY ||
                         (rules[i].coil == c && rules[i].sw == sw)) begin
                        rules[i].rtype = typ;
                        rules[i].sw = sw;
                        rules[i].coil = c;
                        rules[i].st = cre_pkg::S_ENABLED;
                        rules[i].timeout = '0;
                        rules[i].duration = dur;
                        push_write(c, 1'b0);
                        push_status(cre_pkg::ST_OK);
                        done = 1'b1;
                     end
                  if (!done) push_status(cre_pkg::ST_TABLE_FULL);
               end
            end
            cre_pkg::CMD_RELEASE: begin
               for (int i = 0; i < cre_pkg::RULE_COUNT && !done; i++)
                  if (rules[i].rtype == cre_pkg::T_ENABLE && rules[i].coil == c) begin
                     rules[i].st = cre_pkg::S_RELEASE;
                     done = 1'b1;
                  end
               push_status(done ? cre_pkg::ST_OK : cre_pkg::ST_NOT_FOUND);
            end
            cre_pkg::CMD_CLEAR: begin
               for (int i = 0; i < cre_pkg::RULE_COUNT && !done; i++)
                  if (rules[i].sw == sw && rules[i].coil == c) begin
                     rules[i].st = cre_pkg::S_CLEAR;
                     done = 1'b1;
                  end
               push_status(cre_pkg::ST_OK);
            end
            cre_pkg::CMD_CLEAR_ALL: begin
               for (int i = 0; i < cre_pkg::RULE_COUNT; i++) rules[i].st = cre_pkg::S_CLEAR;
               push_status(cre_pkg::ST_OK);
            end
            cre_pkg::CMD_STOP_ALL: begin
               for (int i = 0; i < cre_pkg::RULE_COUNT; i++)
                  if (rules[i].rtype != cre_pkg::T_EMPTY && rules[i].st != cre_pkg::S_DISABLED)
                     rules[i].st = cre_pkg::S_RELEASE;
               push_status(cre_pkg::ST_OK);
            end
            default: push_status(cre_pkg::ST_OK);
         endcase
      endfunction

      function void check_result(coil_result_type got);
         coil_result_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result kind=%0d status=%0d", got.kind, got.status);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.kind !== exp.kind) begin
            $error("kind exp %0d got %0d", exp.kind, got.kind); errors++;
         end
         if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); errors++;
         end
         if (got.coil_number !== exp.coil_number) begin
            $error("coil_number exp %0d got %0d", exp.coil_number, got.coil_number);
            errors++;
         end
         if (got.level !== exp.level) begin
            $error("level exp %0d got %0d", exp.level, got.level); errors++;
         end
         if (got.last !== exp.last) begin
            $error("last exp %0d got %0d", exp.last, got.last); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [2:0]  req_rule_type = '0;
   logic [5:0]  req_enable_switch = '0;
   logic [6:0]  req_coil = '0;
   logic [15:0] req_duration = '0;
   logic [15:0] req_now = '0;
   logic [63:0] req_switch_active = '0;
   logic        rsp_valid;
   logic        rsp_kind;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_coil_number;
   logic        rsp_level;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic        paddr = 1'b0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   scoreboard_type board;
   logic           idle_en = 1'b1;
   logic [15:0]    clock_now = '0;

   always #5 clock = ~clock;

   coil_rule_engine_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_rule_type(req_rule_type),
      .req_enable_switch(req_enable_switch), .req_coil(req_coil),
      .req_duration(req_duration), .req_now(req_now),
      .req_switch_active(req_switch_active),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_status(rsp_status),
      .rsp_coil_number(rsp_coil_number), .rsp_level(rsp_level), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always @(posedge clock) begin
      coil_result_type r;
      if (!reset && rsp_valid) begin
         r.kind = rsp_kind;
         r.status = rsp_status;
         r.coil_number = rsp_coil_number;
         r.level = rsp_level;
         r.last = rsp_last;
         board.check_result(r);
      end
   end

   task automatic write_present(logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= value; penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      board.present = value;
   endtask

   task automatic send_request(logic [2:0] cmd, logic [2:0] typ, logic [5:0] sw,
                               logic [6:0] c, logic [15:0] dur, logic [15:0] now,
                               logic [63:0] act);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_command <= cmd; req_rule_type <= typ; req_enable_switch <= sw;
      req_coil <= c; req_duration <= dur; req_now <= now; req_switch_active <= act;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_request(cmd, typ, sw, c, dur, now, act);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (board.pending.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic tick(logic [63:0] act);
      clock_now = clock_now + 16'($urandom_range(0, 300));
      send_request(cre_pkg::CMD_TICK, '0, '0, '0, '0, clock_now, act);
   endtask

   task automatic random_run(int count);
      logic [5:0]  sw;
      logic [6:0]  c;
      logic [63:0] act;
      int          pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         sw = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(1, 12));
         c = ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8));
         act = {$urandom, $urandom};
         if (pick < 45) tick(act);
         else if (pick < 70)
            send_request(cre_pkg::CMD_ADD, 3'($urandom_range(0, 7)), sw, c,
                         16'($urandom_range(0, 600)), '0, act);
         else if (pick < 80) send_request(cre_pkg::CMD_RELEASE, '0, sw, c, '0, '0, act);
         else if (pick < 90) send_request(cre_pkg::CMD_CLEAR, '0, sw, c, '0, '0, act);
         else if (pick < 94) send_request(cre_pkg::CMD_STOP_ALL, '0, '0, '0, '0, '0, act);
         else if (pick < 97) send_request(cre_pkg::CMD_CLEAR_ALL, '0, '0, '0, '0, '0, act);
         else
            send_request(3'($urandom_range(0, 7)), 3'($urandom), 6'($urandom), 7'($urandom),
                         16'($urandom), 16'($urandom), act);
      end
   endtask

   initial begin
      #5000000;
      $display("coil_rule_engine_core test failed");
      $finish;
   end

   initial begin
      board = new();
      board.clear_table();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_present(64'hFFFF_FFFF_FFFF_FFFF);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_PULSE, 6'd0, 7'd1, 16'd10, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_ENABLE, 6'd63, 7'd100, 16'hFFFF, '0, '1);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_HIT, 6'd5, 7'd2, 16'hFFF0, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_HIT_REL, 6'd6, 7'd3, 16'd0, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_HIT_EN_REL, 6'd7, 7'd4, 16'd5, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_HIT_EN_REL_DIS, 6'd8, 7'd5, 16'd5, '0, '0);
      send_request(cre_pkg::CMD_ADD, 3'd7, 6'd9, 7'd6, 16'd5, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_EMPTY, 6'd0, 7'd7, 16'd5, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_PULSE, 6'd0, 7'd0, 16'd5, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_PULSE, 6'd0, 7'd101, 16'd5, '0, '0);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_HIT, 6'd0, 7'd9, 16'd5, '0, '0);
      for (int i = 0; i < 5; i++)
         send_request(cre_pkg::CMD_TICK, '0, '0, '0, '0, 16'hFFF8 + 16'(i * 3), '1);
      send_request(cre_pkg::CMD_TICK, '0, '0, '0, '0, 16'hFFFF, '0);
      send_request(cre_pkg::CMD_RELEASE, '0, '0, 7'd100, '0, '0, '0);
      send_request(cre_pkg::CMD_RELEASE, '0, '0, 7'd55, '0, '0, '0);
      send_request(cre_pkg::CMD_CLEAR, '0, 6'd5, 7'd2, '0, '0, '0);
      send_request(cre_pkg::CMD_STOP_ALL, '0, '0, '0, '0, '0, '0);
      send_request(cre_pkg::CMD_TICK, '0, '0, '0, '0, 16'd0, '0);
      send_request(cre_pkg::CMD_CLEAR_ALL, '0, '0, '0, '0, '0, '0);
      send_request(cre_pkg::CMD_RSV6, '0, '0, '0, '0, '0, '0);
      send_request(cre_pkg::CMD_RSV7, '0, '0, '0, '0, '0, '0);
      send_request(cre_pkg::CMD_TICK, '0, '0, '0, '0, 16'd1, '0);
      drain();

      write_present(64'h0000_0000_0000_0000);
      send_request(cre_pkg::CMD_ADD, cre_pkg::T_HIT, 6'd3, 7'd3, 16'd3, '0, '0);
      for (int s = 0; s < 18; s++)
         send_request(cre_pkg::CMD_ADD, cre_pkg::T_PULSE, 6'd0, 7'(s + 1), '0, '0, '0);
      drain();

      write_present({$urandom, $urandom} | 64'h0000_0000_0000_1FFE);
      random_run(70);
      drain();
      write_present(64'h0000_0000_0000_0AAA);
      random_run(70);
      idle_en = 1'b0;
      random_run(40);
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("coil_rule_engine_core test passed");
      else
         $display("coil_rule_engine_core test failed");
      $finish;
   end
endmodule
